FILE: rtl/mtss_pkg.sv
// shared types, constants and the saturating adder for the three-run maximum sum block
// no dependencies
package mtss_pkg;

    localparam int SUM_WIDTH = 64;

    typedef logic signed [SUM_WIDTH-1:0] sum_t;

    localparam sum_t SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // per-lane control from the item counter
    typedef struct packed {
        logic enable;      // lane has enough items to hold a value after this one
        logic self_valid;  // lane held a value before this item
    } lane_ctrl_t;

    function automatic sum_t sat_add(input sum_t x, input sum_t y);
        sum_t s;
        s = x + y;
        if ((x[SUM_WIDTH-1] == y[SUM_WIDTH-1]) && (s[SUM_WIDTH-1] != x[SUM_WIDTH-1])) begin
            s = x[SUM_WIDTH-1] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

endpackage

FILE: rtl/max_three_subarray_sum.sv
// top level of the streaming maximum total of K disjoint ordered runs
// depends on mtss_pkg and mtss_lane

// Takes one signed sample per transfer on the s_axis stream, tlast marking the end of a
// sequence, and on that last sample gives one result on m_axis: the greatest total of K
// non-empty, non-overlapping, ordered contiguous runs (tdata, signed 64 bits, sums
// saturate) and a flag in tuser that is 1 only if the sequence held at least K samples
// (tdata is 0 otherwise). A new sample is taken every cycle unless a last sample is
// stalled; the K lanes of the recurrence update their state registers once per sample,
// and that feedback loop sets the rate. Only a last sample can stall: it waits in the
// input register while the output register holds a result that has not yet been
// transferred. A sample is held in the input register until it is consumed; an ordinary
// sample is then folded into the state, while a last sample is folded into the result
// in the output register, and the state clears after each last sample.
module max_three_subarray_sum
    import mtss_pkg::*;
#(
    parameter int K            = 3,
    parameter int SAMPLE_WIDTH = 32,
    localparam int SDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int CNT_W       = $clog2(K + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [SDATA_W-1:0] s_axis_tdata,   // sample
    input  logic               s_axis_tlast,   // last
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [SUM_WIDTH-1:0] m_axis_tdata, // best_sum
    output logic [0:0]         m_axis_tuser    // valid_res
);

    logic [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic                    in_last_reg;
    logic                    in_valid_reg;

    sum_t end_reg   [K];
    sum_t prefix_reg[K];
    sum_t end_next   [K];
    sum_t prefix_next[K];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic               out_valid_reg;
    logic [SUM_WIDTH-1:0] out_sum_reg;
    logic               out_flag_reg;

    logic out_free;
    logic in_consume;
    sum_t sample_ext;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_consume    = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || in_consume;

    assign sample_ext = {{(SUM_WIDTH-SAMPLE_WIDTH){in_sample_reg[SAMPLE_WIDTH-1]}},
                         in_sample_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_sample_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            in_last_reg   <= s_axis_tlast;
        end
    end

    genvar j;
    generate
        for (j = 0; j < K; j++) begin : g_lane
            localparam logic [CNT_W:0] Runs = (CNT_W+1)'(j + 1);
            lane_ctrl_t ctrl;
            sum_t       start_base;

            // enable, then self_valid
            assign ctrl = {(({1'b0, count_reg} + (CNT_W+1)'(1)) >= Runs),
                           ({1'b0, count_reg} >= Runs)};

            if (j == 0) begin : g_first
                assign start_base = '0;
            end else begin : g_rest
                assign start_base = prefix_reg[j-1];
            end

            mtss_lane u_lane (
                .ctrl        (ctrl),
                .start_base  (start_base),
                .end_best    (end_reg[j]),
                .prefix_best (prefix_reg[j]),
                .sample      (sample_ext),
                .end_next    (end_next[j]),
                .prefix_next (prefix_next[j])
            );
        end
    endgenerate

    // saturating count of samples in the current sequence
    assign count_next = (count_reg < CNT_W'(K)) ? (count_reg + CNT_W'(1)) : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < K; i++) begin
                end_reg[i]    <= '0;
                prefix_reg[i] <= '0;
            end
        end else if (in_consume) begin
            if (in_last_reg) begin
                count_reg <= '0;
                for (int i = 0; i < K; i++) begin
                    end_reg[i]    <= '0;
                    prefix_reg[i] <= '0;
                end
            end else begin
                count_reg <= count_next;
                for (int i = 0; i < K; i++) begin
                    end_reg[i]    <= end_next[i];
                    prefix_reg[i] <= prefix_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_consume && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (in_consume && in_last_reg) begin
            if (count_next >= CNT_W'(K)) begin
                out_sum_reg  <= prefix_next[K-1];
                out_flag_reg <= 1'b1;
            end else begin
                out_sum_reg  <= '0;
                out_flag_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_sum_reg;
    assign m_axis_tuser[0] = out_flag_reg;

endmodule

FILE: rtl/mtss_lane.sv
// one run-count lane of the recurrence: best total ending here and best total so far
// depends on mtss_pkg
module mtss_lane
    import mtss_pkg::*;
(
    input  lane_ctrl_t ctrl,
    input  sum_t       start_base,   // best total of one run fewer, or zero for the first lane
    input  sum_t       end_best,
    input  sum_t       prefix_best,
    input  sum_t       sample,
    output sum_t       end_next,
    output sum_t       prefix_next
);

    sum_t base;
    sum_t sum;

    always_comb begin
        base = start_base;
        // extend the run that ended at the previous item when that is better
        if (ctrl.self_valid && (end_best > base)) begin
            base = end_best;
        end
        sum = sat_add(base, sample);
        if (!ctrl.enable) begin
            end_next    = '0;
            prefix_next = '0;
        end else begin
            end_next    = sum;
            prefix_next = (ctrl.self_valid && (prefix_best > sum)) ? prefix_best : sum;
        end
    end

endmodule
